[sv/integer_constant_fold_alu_macros.svh]
// Assertion macros for the constant fold ALU
`ifndef INTEGER_CONSTANT_FOLD_ALU_MACROS_SVH
`define INTEGER_CONSTANT_FOLD_ALU_MACROS_SVH
`ifndef SYNTHESIS
`define ICF_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ICF_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ICF_ASSERT(label, clk, rst, prop, msg)
`define ICF_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

[sv/icf_pkg.sv]
package icf_pkg;
  localparam int W = 32;
  localparam int DivStages = W;

  typedef enum logic [4:0] {
    OP_EQ = 5'd0, OP_NE = 5'd1, OP_LE = 5'd2, OP_LT = 5'd3, OP_GE = 5'd4,
    OP_GT = 5'd5, OP_ULE = 5'd6, OP_ULT = 5'd7, OP_UGE = 5'd8, OP_UGT = 5'd9,
    OP_ADD = 5'd10, OP_SUB = 5'd11, OP_MUL = 5'd12, OP_DIV = 5'd13,
    OP_MOD = 5'd14, OP_AND = 5'd15, OP_OR = 5'd16, OP_XOR = 5'd17,
    OP_SHL = 5'd18, OP_SHR = 5'd19, OP_NEG = 5'd20, OP_LNOT = 5'd21,
    OP_COMPL = 5'd22, OP_CONV = 5'd23
  } op_t;

  localparam logic [3:0] TT_CHAR = 4'd0, TT_SHORT = 4'd1, TT_INT = 4'd2, TT_LONG = 4'd3,
    TT_UCHAR = 4'd4, TT_USHORT = 4'd5, TT_UNS = 4'd6, TT_ULONG = 4'd7, TT_PTR = 4'd8;

  typedef struct packed {
    logic [4:0]  op;
    logic [31:0] a_value;
    logic [31:0] b_value;
    logic        a_is_unsigned;
    logic        a_is_pointer;
    logic        b_is_unsigned;
    logic        b_is_pointer;
    logic [3:0]  target_type;
  } req_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic        folded;
    logic        divide_by_zero;
  } rsp_t;

  // classified request handed from front to back
  typedef struct packed {
    logic        is_div;      // takes divider path
    logic        is_mul;      // takes multiplier path
    logic        want_rem;
    logic        neg_q;       // negate quotient at end
    logic        neg_r;       // negate remainder at end
    logic [W-1:0] da;         // divider operand magnitudes, or raw multiplier operands
    logic [W-1:0] db;
    rsp_t        simple;      // result for ops evaluated in the front end
  } cls_t;
endpackage

[sv/icf_if.sv]
interface icf_req_if;
  import icf_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface icf_rsp_if;
  import icf_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/integer_constant_fold_alu.sv]
// 32-bit constant-fold ALU with C integer rules. Requests are accepted one per
// cycle when the output is not stalled. Each passes one classify stage, a
// 4-entry queue, the back-end input register, a multiply stage and 32
// restoring-divide stages that every request passes through; the result is
// taken from the last one. Division by zero returns folded=0, divide_by_zero=1.
module integer_constant_fold_alu (
  input  logic      clk,
  input  logic      rst,
  icf_req_if.sink   req,
  icf_rsp_if.source rsp
);
  import icf_pkg::*;

  logic fv, fr, qv, qr;
  cls_t fc, qc;

  icf_front u_front (.clk, .rst, .req, .cls_valid(fv), .cls_ready(fr), .cls(fc));
  icf_queue u_queue (.clk, .rst, .in_valid(fv), .in_ready(fr), .in_data(fc),
                     .out_valid(qv), .out_ready(qr), .out_data(qc));
  icf_back u_back (.clk, .rst, .in_valid(qv), .in_ready(qr), .in_data(qc), .rsp);
endmodule

[sv/icf_front.sv]
module icf_front (
  input  logic            clk,
  input  logic            rst,
  icf_req_if.sink         req,
  output logic            cls_valid,
  input  logic            cls_ready,
  output icf_pkg::cls_t   cls
);
  import icf_pkg::*;

  logic [W-1:0] a, b;
  logic uns_rel, uns_ar, na, nb, lt_s, lt_u, eq, big;
  logic [W-1:0] ma, mb, shl_r, shr_r;
  cls_t c;
  logic [31:0] rv;
  logic ok;

  // classify and evaluate the cheap ops
  always_comb begin
    a = req.data.a_value;
    b = req.data.b_value;
    uns_rel = req.data.a_is_unsigned | req.data.a_is_pointer |
              req.data.b_is_unsigned | req.data.b_is_pointer;
    uns_ar = req.data.a_is_unsigned | req.data.b_is_unsigned;
    na = a[W-1] & ~uns_ar;
    nb = b[W-1] & ~uns_ar;
    ma = na ? (~a + 1'b1) : a;
    mb = nb ? (~b + 1'b1) : b;
    eq = (a == b);
    lt_u = (a < b);
    lt_s = ($signed(a) < $signed(b));
    big = (b >= W);
    shl_r = big ? '0 : (a << b[$clog2(W)-1:0]);
    // negative signed value: shift the complement and fill with ones
    if (req.data.a_is_unsigned || !a[W-1])
      shr_r = big ? '0 : (a >> b[$clog2(W)-1:0]);
    else
      shr_r = big ? '1 : ~((~a) >> b[$clog2(W)-1:0]);
    rv = '0;
    ok = 1'b1;
    unique case (req.data.op)
      OP_EQ: rv = {31'd0, eq};
      OP_NE: rv = {31'd0, ~eq};
      OP_LE: rv = {31'd0, uns_rel ? (lt_u | eq) : (lt_s | eq)};
      OP_LT: rv = {31'd0, uns_rel ? lt_u : lt_s};
      OP_GE: rv = {31'd0, uns_rel ? ~lt_u : ~lt_s};
      OP_GT: rv = {31'd0, uns_rel ? ~(lt_u | eq) : ~(lt_s | eq)};
      OP_ULE: rv = {31'd0, lt_u | eq};
      OP_ULT: rv = {31'd0, lt_u};
      OP_UGE: rv = {31'd0, ~lt_u};
      OP_UGT: rv = {31'd0, ~(lt_u | eq)};
      OP_ADD: rv = a + b;
      OP_SUB: rv = a - b;
      OP_AND: rv = a & b;
      OP_OR: rv = a | b;
      OP_XOR: rv = a ^ b;
      OP_SHL: rv = shl_r;
      OP_SHR: rv = shr_r;
      OP_NEG: rv = ~a + 1'b1;
      OP_LNOT: rv = {31'd0, a == '0};
      OP_COMPL: rv = ~a;
      OP_CONV: begin
        unique case (req.data.target_type)
          TT_CHAR: rv = {{24{a[7]}}, a[7:0]};
          TT_SHORT: rv = {{16{a[15]}}, a[15:0]};
          TT_UCHAR: rv = {24'd0, a[7:0]};
          TT_USHORT: rv = {16'd0, a[15:0]};
          TT_INT, TT_LONG, TT_UNS, TT_ULONG, TT_PTR: rv = a;
          default: ok = 1'b0;
        endcase
      end
      OP_MUL, OP_DIV, OP_MOD: rv = '0;
      default: ok = 1'b0;
    endcase
    c.is_mul = (req.data.op == OP_MUL);
    c.is_div = ((req.data.op == OP_DIV) || (req.data.op == OP_MOD)) && (b != '0);
    c.want_rem = (req.data.op == OP_MOD);
    c.neg_q = na ^ nb;
    c.neg_r = na;
    c.da = c.is_mul ? a : ma;
    c.db = c.is_mul ? b : mb;
    c.simple.result_value = ok ? rv : '0;
    c.simple.folded = ok && !((req.data.op == OP_DIV || req.data.op == OP_MOD) && b == '0);
    c.simple.divide_by_zero = (req.data.op == OP_DIV || req.data.op == OP_MOD) && b == '0;
  end

  // output register toward the queue
  assign req.ready = ~cls_valid | cls_ready;
  always_ff @(posedge clk) begin
    if (rst) begin
      cls_valid <= 1'b0;
    end else if (req.ready) begin
      cls_valid <= req.valid;
    end
    if (req.ready && req.valid) begin
      cls <= c;
    end
  end
endmodule

[sv/icf_queue.sv]
module icf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  icf_pkg::cls_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output icf_pkg::cls_t out_data
);
  import icf_pkg::*;
  `include "integer_constant_fold_alu_macros.svh"

  localparam int Depth = 4;
  cls_t mem [Depth];
  logic [1:0] wp, rp;
  logic [2:0] count;
  logic push, pop;

  assign in_ready = (count != 3'(Depth));
  assign out_valid = (count != '0);
  assign push = in_valid & in_ready;
  assign pop = out_valid & out_ready;
  assign out_data = mem[rp];

  // small FIFO between classify and execute
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      count <= count + 3'(push) - 3'(pop);
    end
    if (push) mem[wp] <= in_data;
  end

  `ICF_ASSERT(a_cnt_max, clk, rst, count <= 3'(Depth), "queue overfull")
  `ICF_ASSERT(a_cnt_step, clk, rst, (push && !pop) |=> count == $past(count) + 3'd1, "count slip")
  `ICF_ASSERT(a_ptr_gap, clk, rst, (count == '0 || count == 3'(Depth)) |-> wp == rp, "ptr gap")
endmodule

[sv/icf_back.sv]
module icf_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  icf_pkg::cls_t in_data,
  icf_rsp_if.source     rsp
);
  import icf_pkg::*;
  `include "integer_constant_fold_alu_macros.svh"

  localparam int N = DivStages + 2;

  // pipeline stage record: divider state rides with each request
  typedef struct packed {
    cls_t         c;
    logic [W-1:0] rem;
    logic [W-1:0] quo;
  } stg_t;

  logic   vld [N];
  stg_t   st  [N];
  stg_t   nx  [N];
  logic   adv;
  logic [2*W-1:0] prod;
  logic [W-1:0] q, r, res;

  // whole pipe moves when the last stage can leave
  assign adv = ~vld[N-1] | rsp.ready;
  assign in_ready = adv;

  // stage 0: input register; stage 1: multiply; stages 2..W+1: one restoring divide step each
  always_comb begin
    prod = st[0].c.da * st[0].c.db;
    nx[0].c = in_data;
    nx[0].rem = '0;
    nx[0].quo = in_data.da;
    nx[1] = st[0];
    if (st[0].c.is_mul) nx[1].quo = prod[W-1:0];
    for (int i = 2; i < N; i++) begin
      logic [W:0] t;
      t = {st[i-1].rem, st[i-1].quo[W-1]};
      nx[i] = st[i-1];
      if (st[i-1].c.is_div) begin
        if (t >= {1'b0, st[i-1].c.db}) begin
          nx[i].rem = W'(t - {1'b0, st[i-1].c.db});
          nx[i].quo = {st[i-1].quo[W-2:0], 1'b1};
        end else begin
          nx[i].rem = t[W-1:0];
          nx[i].quo = {st[i-1].quo[W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) vld[i] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int i = 1; i < N; i++) vld[i] <= vld[i-1];
    end
    if (adv) begin
      for (int i = 0; i < N; i++) st[i] <= nx[i];
    end
  end

  // final sign fix and result select
  always_comb begin
    q = st[N-1].c.neg_q ? (~st[N-1].quo + 1'b1) : st[N-1].quo;
    r = st[N-1].c.neg_r ? (~st[N-1].rem + 1'b1) : st[N-1].rem;
    if (st[N-1].c.is_div) res = st[N-1].c.want_rem ? r : q;
    else if (st[N-1].c.is_mul) res = st[N-1].quo;
    else res = st[N-1].c.simple.result_value;
    rsp.data.result_value = 32'(res);
    rsp.data.folded = st[N-1].c.simple.folded;
    rsp.data.divide_by_zero = st[N-1].c.simple.divide_by_zero;
  end
  assign rsp.valid = vld[N-1];

  `ICF_ASSERT(a_dz_nofold, clk, rst, rsp.valid && rsp.data.divide_by_zero |-> !rsp.data.folded, "dz folded")
  `ICF_ASSERT(a_dz_zero, clk, rst, rsp.valid && rsp.data.divide_by_zero |-> rsp.data.result_value == '0, "dz value")
  `ICF_ASSERT(a_hold, clk, rst, rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data), "stall lost")
endmodule

[tb/icf_checker.sv]
module icf_checker
  import icf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  input  logic    req_ready,
  input  req_t    req_data,
  input  logic    rsp_valid,
  input  logic    rsp_ready,
  input  rsp_t    rsp_data,
  output int      fail_count,
  output int      pending,
  output int      checked
);
  timeunit 1ns;
  timeprecision 1ps;

  rsp_t expected_q[$];

  // signed less-than on 32-bit words
  function automatic bit s_less(logic [31:0] x, logic [31:0] y);
    return $signed(x) < $signed(y);
  endfunction

  // fold one request the way a C compiler would
  function automatic rsp_t fold_request(req_t r);
    rsp_t o;
    logic [31:0] a, b, ma, mb, q;
    bit uns_rel, uns_ar, na, nb;
    a = r.a_value;
    b = r.b_value;
    uns_rel = r.a_is_unsigned | r.a_is_pointer | r.b_is_unsigned | r.b_is_pointer;
    uns_ar = r.a_is_unsigned | r.b_is_unsigned;
    o = '0;
    o.folded = 1'b1;
    case (r.op)
      OP_EQ:  o.result_value = {31'd0, a == b};
      OP_NE:  o.result_value = {31'd0, a != b};
      OP_LE:  o.result_value = {31'd0, uns_rel ? a <= b : !s_less(b, a)};
      OP_LT:  o.result_value = {31'd0, uns_rel ? a < b : s_less(a, b)};
      OP_GE:  o.result_value = {31'd0, uns_rel ? a >= b : !s_less(a, b)};
      OP_GT:  o.result_value = {31'd0, uns_rel ? a > b : s_less(b, a)};
      OP_ULE: o.result_value = {31'd0, a <= b};
      OP_ULT: o.result_value = {31'd0, a < b};
      OP_UGE: o.result_value = {31'd0, a >= b};
      OP_UGT: o.result_value = {31'd0, a > b};
      OP_ADD: o.result_value = a + b;
      OP_SUB: o.result_value = a - b;
      OP_MUL: o.result_value = a * b;
      OP_DIV, OP_MOD: begin
        if (b == 0) begin
          o.folded = 1'b0;
          o.divide_by_zero = 1'b1;
        end else if (uns_ar) begin
          o.result_value = (r.op == OP_DIV) ? a / b : a % b;
        end else begin
          // magnitudes; the minimum value negates to itself, which is right unsigned
          na = a[31];
          nb = b[31];
          ma = na ? -a : a;
          mb = nb ? -b : b;
          if (r.op == OP_DIV) begin
            q = ma / mb;
            o.result_value = (na != nb) ? -q : q;
          end else begin
            q = ma % mb;
            o.result_value = na ? -q : q;
          end
        end
      end
      OP_AND: o.result_value = a & b;
      OP_OR:  o.result_value = a | b;
      OP_XOR: o.result_value = a ^ b;
      OP_SHL: o.result_value = (b >= 32) ? '0 : a << b[4:0];
      OP_SHR: begin
        if (r.a_is_unsigned || !a[31])
          o.result_value = (b >= 32) ? '0 : a >> b[4:0];
        else
          o.result_value = (b >= 32) ? '1 : ~((~a) >> b[4:0]);
      end
      OP_NEG:   o.result_value = -a;
      OP_LNOT:  o.result_value = {31'd0, a == 0};
      OP_COMPL: o.result_value = ~a;
      OP_CONV: begin
        case (r.target_type)
          TT_CHAR:   o.result_value = {{24{a[7]}}, a[7:0]};
          TT_SHORT:  o.result_value = {{16{a[15]}}, a[15:0]};
          TT_UCHAR:  o.result_value = {24'd0, a[7:0]};
          TT_USHORT: o.result_value = {16'd0, a[15:0]};
          TT_INT, TT_LONG, TT_UNS, TT_ULONG, TT_PTR: o.result_value = a;
          default: o.folded = 1'b0;
        endcase
      end
      default: o.folded = 1'b0;
    endcase
    return o;
  endfunction

  always_ff @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      fail_count <= 0;
      pending <= 0;
      checked <= 0;
    end else begin
      if (req_valid && req_ready)
        expected_q.push_back(fold_request(req_data));
      if (rsp_valid && rsp_ready) begin
        checked <= checked + 1;
        if (expected_q.size() == 0) begin
          if (fail_count < 10)
            $display("ERROR: unexpected result %h/%b/%b", rsp_data.result_value,
                     rsp_data.folded, rsp_data.divide_by_zero);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (want !== rsp_data) begin
            if (fail_count < 10)
              $display("ERROR: result %0d expected %h/%b/%b got %h/%b/%b", checked,
                       want.result_value, want.folded, want.divide_by_zero,
                       rsp_data.result_value, rsp_data.folded, rsp_data.divide_by_zero);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_q.size();
    end
  end
endmodule

[tb/tb_integer_constant_fold_alu.sv]
module tb_integer_constant_fold_alu;
  import icf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count, pending, checked;
  int   sent = 0;

  icf_req_if req_ch ();
  icf_rsp_if rsp_ch ();

  integer_constant_fold_alu u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  icf_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_ch.valid),
    .req_ready  (req_ch.ready),
    .req_data   (req_ch.data),
    .rsp_valid  (rsp_ch.valid),
    .rsp_ready  (rsp_ch.ready),
    .rsp_data   (rsp_ch.data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // idle roughly 23% of cycles, except in a quiet window
  function automatic bit take_gap(int phase);
    if (phase >= 150 && phase < 300)
      return 1'b0;
    return $urandom_range(99) < 23;
  endfunction

  // output stall pattern
  initial rsp_ch.ready = 1'b0;
  always @(posedge clk) begin
    if (rst)
      rsp_ch.ready <= 1'b0;
    else
      rsp_ch.ready <= !take_gap(checked);
  end

  // operand values biased toward corner cases
  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h0;
      1: return 32'h1;
      2: return 32'hFFFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'h7FFF_FFFF;
      5: return $urandom_range(40);
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t random_request();
    req_t r;
    r.op = ($urandom_range(15) == 0) ? 5'($urandom_range(31, 24)) : 5'($urandom_range(23));
    r.a_value = pick_word();
    r.b_value = pick_word();
    if ((r.op == OP_SHL || r.op == OP_SHR) && $urandom_range(3) != 0)
      r.b_value = $urandom_range(40);
    {r.a_is_unsigned, r.a_is_pointer, r.b_is_unsigned, r.b_is_pointer} = 4'($urandom);
    r.target_type = 4'($urandom);
    return r;
  endfunction

  function automatic req_t make_request(logic [4:0] op, logic [31:0] a, logic [31:0] b,
                                        logic [3:0] flags, logic [3:0] tt);
    req_t r;
    r.op = op;
    r.a_value = a;
    r.b_value = b;
    {r.a_is_unsigned, r.a_is_pointer, r.b_is_unsigned, r.b_is_pointer} = flags;
    r.target_type = tt;
    return r;
  endfunction

  // hold the request until it is taken
  task automatic send_request(req_t r);
    while (take_gap(sent)) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    @(posedge clk);
    while (!req_ch.ready)
      @(posedge clk);
    sent++;
  endtask

  initial begin
    req_t directed[$];
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // corners: signed vs unsigned compare, overflow divide, zero divisor,
    // large shifts, conversions and unfoldable codes
    directed.push_back(make_request(OP_LT, 32'hFFFF_FFFF, 32'h1, 4'b0000, TT_INT));
    directed.push_back(make_request(OP_LT, 32'hFFFF_FFFF, 32'h1, 4'b0100, TT_INT));
    directed.push_back(make_request(OP_GE, 32'h8000_0000, 32'h7FFF_FFFF, 4'b0001, TT_INT));
    directed.push_back(make_request(OP_UGT, 32'hFFFF_FFFF, 32'h0, 4'b0000, TT_INT));
    directed.push_back(make_request(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 4'b0000, TT_INT));
    directed.push_back(make_request(OP_MOD, 32'h8000_0000, 32'hFFFF_FFFF, 4'b0000, TT_INT));
    directed.push_back(make_request(OP_DIV, 32'hFFFF_FFF9, 32'h2, 4'b0000, TT_INT));
    directed.push_back(make_request(OP_MOD, 32'hFFFF_FFF9, 32'h2, 4'b0000, TT_INT));
    directed.push_back(make_request(OP_DIV, 32'hFFFF_FFF9, 32'h2, 4'b0010, TT_INT));
    directed.push_back(make_request(OP_DIV, 32'h5, 32'h0, 4'b0000, TT_INT));
    directed.push_back(make_request(OP_MOD, 32'h5, 32'h0, 4'b1000, TT_INT));
    directed.push_back(make_request(OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'b0000, TT_INT));
    directed.push_back(make_request(OP_SHL, 32'h1, 32'd32, 4'b0000, TT_INT));
    directed.push_back(make_request(OP_SHR, 32'h8000_0000, 32'd31, 4'b0000, TT_INT));
    directed.push_back(make_request(OP_SHR, 32'h8000_0000, 32'd40, 4'b0000, TT_INT));
    directed.push_back(make_request(OP_SHR, 32'h8000_0000, 32'hFFFF_FFFF, 4'b1000, TT_INT));
    directed.push_back(make_request(OP_NEG, 32'h8000_0000, 32'h0, 4'b0000, TT_INT));
    directed.push_back(make_request(OP_LNOT, 32'h0, 32'h0, 4'b0000, TT_INT));
    directed.push_back(make_request(OP_COMPL, 32'h0, 32'hFFFF_FFFF, 4'b0000, TT_INT));
    directed.push_back(make_request(OP_CONV, 32'h0000_0080, 32'h0, 4'b0000, TT_CHAR));
    directed.push_back(make_request(OP_CONV, 32'h1234_8000, 32'h0, 4'b0000, TT_SHORT));
    directed.push_back(make_request(OP_CONV, 32'hFFFF_FFFF, 32'h0, 4'b0000, TT_USHORT));
    directed.push_back(make_request(OP_CONV, 32'hFFFF_FFFF, 32'h0, 4'b0000, 4'd15));
    directed.push_back(make_request(5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'b1111, TT_PTR));
    foreach (directed[i])
      send_request(directed[i]);

    repeat (450)
      send_request(random_request());
    req_ch.valid <= 1'b0;

    // drain, then let the pipeline settle
    while (pending != 0 || checked < sent)
      @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Covered %0d requests: all opcodes, sign/pointer flag mixes, shifts, converts,",
             sent);
    $display("zero divisors and unfoldable codes, with random input and output stalls.");
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #2ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule
